// File: hw/rtl/ppmr_pkg.sv
// ----------------------------------------------------------------------------
// ppmr_pkg: shared types and constants
// Word layouts, register indexes, reading status codes and the
// controller/datapath command and status bundles of the power meter readout.
// ----------------------------------------------------------------------------
package ppmr_pkg;

  localparam int unsigned ScaleW  = 40;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned ValueW  = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 40;

  localparam logic [TimeW-1:0]  ForceZeroUs     = 32'd10_000_000;
  localparam logic [TimeW-1:0]  MsToUs          = 32'd1000;
  localparam logic [TimeW-1:0]  ThreshReset     = 32'd1_000_000;
  localparam logic [15:0]       ModeEveryReset  = 16'd8;
  localparam logic [15:0]       ModeCountMax    = 16'hFFFF;
  localparam logic [2:0]        SensorsReset    = 3'b111;
  localparam logic [1:0]        WarmupTicks     = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_POWER_SCALE   = 3'd0,
    CFG_CURRENT_SCALE = 3'd1,
    CFG_VOLTAGE_SCALE = 3'd2,
    CFG_UPDATE_MS     = 3'd3,
    CFG_MODE_EVERY    = 3'd4,
    CFG_SENSORS       = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    RD_UNKNOWN = 2'd0,
    RD_ZERO    = 2'd1,
    RD_NONZERO = 2'd2
  } rd_status_e;

  typedef struct packed {
    logic [TimeW-1:0] now_us;
    logic [TimeW-1:0] power_rise_us;
    logic [TimeW-1:0] power_period_us;
    logic [TimeW-1:0] chan_rise_us;
    logic [TimeW-1:0] chan_period_us;
    logic             chan_period_valid;
  } in_word_t;

  typedef struct packed {
    logic              power_publish;
    logic [ValueW-1:0] power_value;
    logic              chan_publish;
    logic              chan_is_current;
    logic [ValueW-1:0] chan_value;
    logic              select_level;
    logic              clear_chan_capture;
  } out_word_t;

  typedef struct packed {
    logic cap;        // capture input word
    logic div_start;
    logic div_chan;   // divider operands: 0 power, 1 channel
    logic p_load;
    logic c_load;
    logic commit;     // update state, load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic p_need;
    logic c_need;
    logic div_done;
  } ctrl_sts_t;

endpackage

// File: hw/rtl/ppmr_if.sv
// ----------------------------------------------------------------------------
// ppmr_if: valid/ready channels
// Input word channel and result word channel of the power meter readout.
// ----------------------------------------------------------------------------
interface ppmr_in_if;
  logic               valid;
  logic               ready;
  ppmr_pkg::in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ppmr_out_if;
  logic                valid;
  logic                ready;
  ppmr_pkg::out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/pulse_power_meter_readout_top.sv
// Flow: an accepted word takes up to two divisions on the shared bit-serial
//   divider, power first, then channel; a new word is accepted only once the
//   last one has been committed to the result register. Warmup words give
//   no result.
// Reset: asynchronous, clears control, mode and status state and loads the
//   register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// pulse_power_meter_readout_top: pulse power meter readout
// Turns pulse periods into power and current/voltage readings, with
// forced-zero, fade-down and channel alternation.
// ----------------------------------------------------------------------------
module pulse_power_meter_readout_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppmr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ppmr_pkg::CfgW-1:0]     cfg_data_i,
  ppmr_in_if.sink                       in_i,
  ppmr_out_if.source                    out_o
);

  ppmr_pkg::ctrl_cmd_t cmd;
  ppmr_pkg::ctrl_sts_t sts;

  ppmr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ppmr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_i.data),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_o.data)
  );

endmodule

// File: hw/rtl/ppmr_div.sv
// ----------------------------------------------------------------------------
// ppmr_div: saturating scale divider
// Restoring divider, one quotient bit per cycle, 40-bit dividend by 32-bit
// divisor. Quotients above 32 bits saturate, a zero divisor gives zero.
// ----------------------------------------------------------------------------
module ppmr_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ppmr_pkg::ScaleW-1:0]   dividend_i,
  input  logic [ppmr_pkg::TimeW-1:0]    divisor_i,
  output logic                          done_o,
  output logic [ppmr_pkg::ValueW-1:0]   quot_o
);

  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [4:0]                    cnt_q, cnt_d;
  logic [ppmr_pkg::TimeW-1:0]    rem_q, rem_d;
  logic [ppmr_pkg::TimeW-1:0]    dvs_q, dvs_d;
  logic [ppmr_pkg::ValueW-1:0]   quo_q, quo_d;
  logic [ppmr_pkg::TimeW:0]      shifted;
  logic                          qbit;
  logic                          dvs_zero;
  logic                          ovf;

  assign shifted  = {rem_q, quo_q[ppmr_pkg::ValueW-1]};
  assign qbit     = (shifted >= {1'b0, dvs_q});
  assign dvs_zero = (divisor_i == '0);
  // quotient needs more than 32 bits when the top byte alone reaches the divisor
  assign ovf      = ({24'd0, dividend_i[ppmr_pkg::ScaleW-1:ppmr_pkg::ValueW]} >= divisor_i);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    quo_d  = quo_q;
    if (start_i) begin
      dvs_d = divisor_i;
      cnt_d = 5'd31;
      rem_d = {24'd0, dividend_i[ppmr_pkg::ScaleW-1:ppmr_pkg::ValueW]};
      if (dvs_zero) begin
        quo_d  = '0;
        done_d = 1'b1;
      end else if (ovf) begin
        quo_d  = '1;
        done_d = 1'b1;
      end else begin
        quo_d  = dividend_i[ppmr_pkg::ValueW-1:0];
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      rem_d = qbit ? shifted[ppmr_pkg::TimeW-1:0] - dvs_q : shifted[ppmr_pkg::TimeW-1:0];
      quo_d = {quo_q[ppmr_pkg::ValueW-2:0], qbit};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: hw/rtl/ppmr_dp.sv
// ----------------------------------------------------------------------------
// ppmr_dp: readout datapath
// Configuration registers, captured word, reading decisions, channel mode
// state, divider and the result register.
// ----------------------------------------------------------------------------
module ppmr_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ppmr_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ppmr_pkg::CfgW-1:0]     cfg_data_i,
  input  ppmr_pkg::in_word_t            in_word_i,
  input  ppmr_pkg::ctrl_cmd_t           cmd_i,
  output ppmr_pkg::ctrl_sts_t           sts_o,
  output ppmr_pkg::out_word_t           out_word_o
);

  // configuration
  logic [ppmr_pkg::ScaleW-1:0] pscale_q, cscale_q, vscale_q;
  logic [ppmr_pkg::TimeW-1:0]  thresh_q;
  logic [15:0]                 every_q;
  logic [2:0]                  sensors_q;

  // state
  ppmr_pkg::rd_status_e        pst_q, cst_q, vst_q;
  logic                        mode_q;
  logic [15:0]                 cnt_q;

  ppmr_pkg::in_word_t          word_q;
  logic [ppmr_pkg::ValueW-1:0] pquot_q, cquot_q;
  ppmr_pkg::out_word_t         out_q;

  logic [ppmr_pkg::TimeW-1:0]  el_p, el_c;
  logic                        p_pres, p_zf, p_fade;
  logic                        c_pres, c_zf, c_fade, c_valid, c_pub, hold;
  ppmr_pkg::rd_status_e        cst_sel;
  logic [ppmr_pkg::ValueW-1:0] p_val, c_val;
  logic [ppmr_pkg::ScaleW-1:0] c_scale, div_dividend;
  logic [ppmr_pkg::TimeW-1:0]  p_dvs, c_dvs, div_divisor;
  logic                        div_done;
  logic [ppmr_pkg::ValueW-1:0] div_quot;
  logic                        toggle_reg;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pscale_q  <= '0;
      cscale_q  <= '0;
      vscale_q  <= '0;
      thresh_q  <= ppmr_pkg::ThreshReset;
      every_q   <= ppmr_pkg::ModeEveryReset;
      sensors_q <= ppmr_pkg::SensorsReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ppmr_pkg::CFG_POWER_SCALE:   pscale_q  <= cfg_data_i;
        ppmr_pkg::CFG_CURRENT_SCALE: cscale_q  <= cfg_data_i;
        ppmr_pkg::CFG_VOLTAGE_SCALE: vscale_q  <= cfg_data_i;
        // keep the threshold in microseconds; 22 bits of ms times 1000 fit 32 bits
        ppmr_pkg::CFG_UPDATE_MS:
          thresh_q <= ppmr_pkg::TimeW'(cfg_data_i[21:0]) * ppmr_pkg::MsToUs;
        ppmr_pkg::CFG_MODE_EVERY:    every_q   <= cfg_data_i[15:0];
        ppmr_pkg::CFG_SENSORS:       sensors_q <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  // power reading decision
  assign el_p   = word_q.now_us - word_q.power_rise_us;
  assign p_pres = sensors_q[0];
  assign p_zf   = (el_p > ppmr_pkg::ForceZeroUs) || (pst_q == ppmr_pkg::RD_UNKNOWN);
  assign p_fade = (el_p > thresh_q) && (el_p > word_q.power_period_us) &&
                  (pst_q == ppmr_pkg::RD_NONZERO);
  assign p_dvs  = p_fade ? el_p : word_q.power_period_us;
  assign p_val  = (p_pres && !p_zf) ? pquot_q : '0;

  // channel reading decision
  assign el_c    = word_q.now_us - word_q.chan_rise_us;
  assign c_valid = word_q.chan_period_valid;
  assign c_pres  = mode_q ? sensors_q[1] : sensors_q[2];
  assign cst_sel = mode_q ? cst_q : vst_q;
  assign c_scale = mode_q ? cscale_q : vscale_q;
  assign c_zf    = (el_c > ppmr_pkg::ForceZeroUs) || (cst_sel == ppmr_pkg::RD_UNKNOWN);
  assign c_fade  = !c_zf && (el_c > thresh_q) && (el_c > word_q.chan_period_us) &&
                   (cst_sel == ppmr_pkg::RD_NONZERO);
  assign c_dvs   = c_valid ? word_q.chan_period_us : el_c;
  assign c_pub   = c_pres && (c_valid || c_zf || c_fade);
  // no counted mode change without a fresh period (fade-down included), unless forced to zero
  assign hold    = !c_pres || (!c_valid && !c_zf);
  assign c_val   = (c_pres && (c_valid || c_fade)) ? cquot_q : '0;
  assign toggle_reg = !hold && (cnt_q >= every_q);

  assign sts_o.p_need   = p_pres && !p_zf;
  assign sts_o.c_need   = c_pres && (c_valid || c_fade);
  assign sts_o.div_done = div_done;

  assign div_dividend = cmd_i.div_chan ? c_scale : pscale_q;
  assign div_divisor  = cmd_i.div_chan ? c_dvs : p_dvs;

  ppmr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap)    word_q  <= in_word_i;
    if (cmd_i.p_load) pquot_q <= div_quot;
    if (cmd_i.c_load) cquot_q <= div_quot;
    if (cmd_i.commit) begin
      out_q.power_publish      <= p_pres;
      out_q.power_value        <= p_val;
      out_q.chan_publish       <= c_pub;
      out_q.chan_is_current    <= c_pub & mode_q;
      out_q.chan_value         <= c_pub ? c_val : '0;
      out_q.select_level       <= (!c_pres || toggle_reg) ? ~mode_q : mode_q;
      out_q.clear_chan_capture <= !c_pres || toggle_reg;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pst_q  <= ppmr_pkg::RD_UNKNOWN;
      cst_q  <= ppmr_pkg::RD_UNKNOWN;
      vst_q  <= ppmr_pkg::RD_UNKNOWN;
      mode_q <= 1'b0;
      cnt_q  <= '0;
    end else if (cmd_i.commit) begin
      if (p_pres) begin
        pst_q <= (p_val == '0) ? ppmr_pkg::RD_ZERO : ppmr_pkg::RD_NONZERO;
      end
      if (c_pub && mode_q) begin
        cst_q <= (c_val == '0) ? ppmr_pkg::RD_ZERO : ppmr_pkg::RD_NONZERO;
      end
      if (c_pub && !mode_q) begin
        vst_q <= (c_val == '0) ? ppmr_pkg::RD_ZERO : ppmr_pkg::RD_NONZERO;
      end
      // absent channel: flip at once, counter restarts at 1 then counts this tick
      if (!c_pres) begin
        mode_q <= ~mode_q;
        cnt_q  <= 16'd2;
      end else if (toggle_reg) begin
        mode_q <= ~mode_q;
        cnt_q  <= 16'd1;
      end else if (cnt_q != ppmr_pkg::ModeCountMax) begin
        cnt_q  <= cnt_q + 16'd1;
      end
    end
  end

  assign out_word_o = out_q;

endmodule

// File: hw/rtl/ppmr_ctrl.sv
// ----------------------------------------------------------------------------
// ppmr_ctrl: readout sequencer
// Warmup count, input/output handshakes and the sequence of power and
// channel divisions for one tick.
// ----------------------------------------------------------------------------
module ppmr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  ppmr_pkg::ctrl_sts_t  sts_i,
  output ppmr_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_PDIV   = 6'b000010,
    ST_PWAIT  = 6'b000100,
    ST_CDIV   = 6'b001000,
    ST_CWAIT  = 6'b010000,
    ST_COMMIT = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] warm_q, warm_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    warm_d      = warm_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          if (warm_q < ppmr_pkg::WarmupTicks) begin
            warm_d = warm_q + 2'd1;
          end else begin
            cmd_o.cap = 1'b1;
            state_d   = ST_PDIV;
          end
        end
      end
      ST_PDIV: begin
        if (sts_i.p_need) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_PWAIT;
        end else begin
          state_d = ST_CDIV;
        end
      end
      ST_PWAIT: begin
        if (sts_i.div_done) begin
          cmd_o.p_load = 1'b1;
          state_d      = ST_CDIV;
        end
      end
      ST_CDIV: begin
        cmd_o.div_chan = 1'b1;
        if (sts_i.c_need) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_CWAIT;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_CWAIT: begin
        cmd_o.div_chan = 1'b1;
        if (sts_i.div_done) begin
          cmd_o.c_load = 1'b1;
          state_d      = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        // result register free, or its word leaves this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      warm_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      warm_q      <= warm_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten");

  a_commit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_o)
    else $error("committed word not offered");

  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_PWAIT || state_q == ST_CWAIT))
    else $error("divider finished outside a wait state");

  a_warm_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    warm_q <= ppmr_pkg::WarmupTicks)
    else $error("warmup count overrun");

endmodule
